/* src/jcm_pkg.sv */
// Package for the word co-occurrence matrix: sizes and codes.
package jcm_pkg;

    localparam int NumWords  = 64;
    localparam int MaxItems  = 1024;
    localparam int WordBits  = 6;
    localparam int ItemBits  = 10;
    localparam int TotalBits = 11;
    localparam int CellBits  = 12;
    localparam int GroupBits = 16;
    localparam int CountBits = 16;

    localparam logic [CountBits-1:0] CountMax = '1;
    localparam logic [16:0] OneQ16 = 17'h10000;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

/* src/jaccard_cooccurrence_matrix.sv */
// Word co-occurrence store with Jaccard similarity readout.
//
// Input channel: in_valid/in_stall with func, word_id, group_id, row_index
// and col_index. Output channel: out_valid/out_stall with status, cell_count,
// ratio_value and is_diagonal, one result item per input item, in order.
// Configuration: cfg_valid/cfg_ready write distance_mode, written when idle.
//
// One item at a time. After reset (and after a clear item) the block sweeps
// the 4096-cell count memory, one cell a cycle, before taking an item; the
// clear item's result follows that sweep. An add does a read-modify-write
// of the count memory for its diagonal and for every match, and walks every
// earlier stored item through the item memory. A read takes three memory
// reads and a 33-step restoring divider; a bad index or an unused func goes
// straight to its result. The count memory has a single port, so its reads
// and writes follow one another. A finished result sits in the output
// register; while the receiver stalls, the next item is still taken and
// run, but its result waits and in_stall stays high, so nothing is lost.
module jaccard_cooccurrence_matrix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [6:0]  word_id,
    input  logic [15:0] group_id,
    input  logic [6:0]  row_index,
    input  logic [6:0]  col_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] cell_count,
    output logic [16:0] ratio_value,
    output logic        is_diagonal,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        distance_mode
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_BUMP_RD, S_BUMP_WAIT, S_BUMP_WR, S_SCAN_RD,
        S_SCAN_CHK, S_RD_C, S_RD_R, S_RD_D, S_RD_WAIT, S_DIV, S_FIN, S_OUT
    } state_t;

    state_t state_reg;
    logic [jcm_pkg::CellBits-1:0]  clr_reg;
    logic                          clr_result_reg;
    logic [jcm_pkg::TotalBits-1:0] total_reg;
    logic [jcm_pkg::TotalBits-1:0] scan_reg;
    logic [jcm_pkg::WordBits-1:0]  w_reg;
    logic [jcm_pkg::GroupBits-1:0] g_reg;
    logic [jcm_pkg::CellBits-1:0]  bump_addr_reg;
    logic [jcm_pkg::WordBits-1:0]  r_reg;
    logic [jcm_pkg::WordBits-1:0]  c_reg;
    logic                          dist_reg;
    logic [jcm_pkg::CountBits-1:0] cnt_reg;
    logic [jcm_pkg::CountBits-1:0] dr_reg;
    logic [17:0]                   den_reg;
    logic [32:0]                   num_reg;
    logic [17:0]                   rem_reg;
    logic [5:0]                    step_reg;
    logic                          lower_reg;

    logic [1:0]  status_reg;
    logic [15:0] cell_count_reg;
    logic [16:0] ratio_reg;
    logic        diag_reg;
    logic        out_valid_reg;

    logic [1:0]  out_status_reg;
    logic [15:0] out_count_reg;
    logic [16:0] out_ratio_reg;
    logic        out_diag_reg;

    // Count memory, single port, registered read
    logic [jcm_pkg::CountBits-1:0] cnt_mem [0:jcm_pkg::NumWords*jcm_pkg::NumWords-1];
    logic [jcm_pkg::CountBits-1:0] cnt_q;
    logic                          cm_we;
    logic [jcm_pkg::CellBits-1:0]  cm_addr;
    logic [jcm_pkg::CountBits-1:0] cm_wdata;

    // Item memory: word and group together
    logic [jcm_pkg::WordBits+jcm_pkg::GroupBits-1:0] item_mem [0:jcm_pkg::MaxItems-1];
    logic [jcm_pkg::WordBits+jcm_pkg::GroupBits-1:0] item_q;
    logic [jcm_pkg::WordBits+jcm_pkg::GroupBits-1:0] im_wdata;
    logic                                            im_we;
    logic [jcm_pkg::ItemBits-1:0]                    im_addr;

    always_ff @(posedge clk)
    begin
        if (cm_we)
            cnt_mem[cm_addr] <= cm_wdata;
        cnt_q <= cnt_mem[cm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (im_we)
            item_mem[im_addr] <= im_wdata;
        item_q <= item_mem[im_addr];
    end

    logic [jcm_pkg::WordBits-1:0]  item_w;
    logic [jcm_pkg::GroupBits-1:0] item_g;
    assign item_w = item_q[jcm_pkg::WordBits+jcm_pkg::GroupBits-1:jcm_pkg::GroupBits];
    assign item_g = item_q[jcm_pkg::GroupBits-1:0];

    logic [6:0] wm1, rm1, cm1;
    assign wm1 = word_id - 7'd1;
    assign rm1 = row_index - 7'd1;
    assign cm1 = col_index - 7'd1;

    logic accept;
    assign accept = (state_reg == S_IDLE) && in_valid;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Only an add that will be stored may touch the item memory
    logic add_ok;
    assign add_ok = (word_id >= 7'd1) && (word_id <= 7'd64) &&
                    (total_reg != 11'(jcm_pkg::MaxItems));
    assign im_wdata = {wm1[jcm_pkg::WordBits-1:0], group_id};

    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Divider step: remainder shifted in one bit of the numerator
    logic [18:0] rem_sh;
    assign rem_sh = {rem_reg, num_reg[32]};

    always_comb
    begin
        cm_we    = 1'b0;
        cm_addr  = bump_addr_reg;
        cm_wdata = '0;
        im_we    = 1'b0;
        im_addr  = scan_reg[jcm_pkg::ItemBits-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                cm_we   = 1'b1;
                cm_addr = clr_reg;
            end
            S_BUMP_WR:
            begin
                cm_we    = (cnt_q != jcm_pkg::CountMax);
                cm_wdata = cnt_q + 1'b1;
            end
            S_IDLE:
            begin
                im_we   = accept && (func == jcm_pkg::FUNC_ADD) && add_ok;
                im_addr = total_reg[jcm_pkg::ItemBits-1:0];
            end
            S_RD_C:   cm_addr = {r_reg, c_reg};
            S_RD_R:   cm_addr = {r_reg, r_reg};
            S_RD_D:   cm_addr = {c_reg, c_reg};
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            clr_result_reg <= 1'b0;
            total_reg      <= '0;
            dist_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_count_reg  <= '0;
            out_ratio_reg  <= '0;
            out_diag_reg   <= 1'b0;
            scan_reg       <= '0;
            step_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                dist_reg <= distance_mode;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == '1)
                    begin
                        if (clr_result_reg)
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg     <= jcm_pkg::ST_OK;
                        cell_count_reg <= '0;
                        ratio_reg      <= '0;
                        diag_reg       <= 1'b0;
                        w_reg          <= wm1[jcm_pkg::WordBits-1:0];
                        g_reg          <= group_id;
                        r_reg          <= rm1[jcm_pkg::WordBits-1:0];
                        c_reg          <= cm1[jcm_pkg::WordBits-1:0];
                        bump_addr_reg  <= {wm1[jcm_pkg::WordBits-1:0],
                                           wm1[jcm_pkg::WordBits-1:0]};
                        scan_reg       <= '0;
                        priority if (func == jcm_pkg::FUNC_ADD)
                        begin
                            if (word_id < 7'd1 || word_id > 7'd64)
                            begin
                                status_reg <= jcm_pkg::ST_BAD;
                                state_reg  <= S_OUT;
                            end
                            else if (total_reg == 11'(jcm_pkg::MaxItems))
                            begin
                                status_reg <= jcm_pkg::ST_FULL;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                total_reg <= total_reg + 1'b1;
                                state_reg <= S_BUMP_RD;
                            end
                        end
                        else if (func == jcm_pkg::FUNC_READ)
                        begin
                            if (row_index < 7'd1 || row_index > 7'd64 ||
                                col_index < 7'd1 || col_index > 7'd64)
                            begin
                                status_reg <= jcm_pkg::ST_BAD;
                                state_reg  <= S_OUT;
                            end
                            else
                                state_reg <= S_RD_C;
                        end
                        else if (func == jcm_pkg::FUNC_CLEAR)
                        begin
                            total_reg      <= '0;
                            clr_reg        <= '0;
                            clr_result_reg <= 1'b1;
                            state_reg      <= S_CLEAR;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                end
                S_BUMP_RD:   state_reg <= S_BUMP_WAIT;
                S_BUMP_WAIT: state_reg <= S_BUMP_WR;
                S_BUMP_WR:
                begin
                    // scan_reg points at the next stored item; the new one is excluded
                    if (scan_reg == total_reg - 1'b1)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SCAN_RD;
                end
                S_SCAN_RD:   state_reg <= S_SCAN_CHK;
                S_SCAN_CHK:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (item_g == g_reg)
                    begin
                        bump_addr_reg <= (w_reg > item_w) ? {w_reg, item_w}
                                                          : {item_w, w_reg};
                        state_reg     <= S_BUMP_RD;
                    end
                    else if (scan_reg + 1'b1 == total_reg - 1'b1)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SCAN_RD;
                end
                S_RD_C:      state_reg <= S_RD_R;
                S_RD_R:
                begin
                    cnt_reg   <= cnt_q;
                    state_reg <= S_RD_D;
                end
                S_RD_D:
                begin
                    dr_reg    <= cnt_q;
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT:
                begin
                    cell_count_reg <= cnt_reg;
                    diag_reg       <= (r_reg == c_reg);
                    lower_reg      <= (r_reg > c_reg);
                    den_reg        <= {2'b00, dr_reg} + {2'b00, cnt_q} - {2'b00, cnt_reg};
                    num_reg        <= {1'b0, cnt_reg, 16'h0000};
                    rem_reg        <= '0;
                    step_reg       <= '0;
                    state_reg      <= S_DIV;
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, den_reg})
                        rem_reg <= 18'(rem_sh - {1'b0, den_reg});
                    else
                        rem_reg <= rem_sh[17:0];
                    num_reg  <= {num_reg[31:0], (rem_sh >= {1'b0, den_reg})};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'd32)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // num_reg now holds the 33-bit quotient
                    if (lower_reg && den_reg != '0 && !den_reg[17])
                    begin
                        if (dist_reg && cnt_reg != '0)
                            ratio_reg <= jcm_pkg::OneQ16 -
                                ((num_reg > 33'(jcm_pkg::OneQ16)) ? jcm_pkg::OneQ16
                                                                  : num_reg[16:0]);
                        else
                            ratio_reg <= (num_reg > 33'(jcm_pkg::OneQ16))
                                         ? jcm_pkg::OneQ16 : num_reg[16:0];
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load)
                    begin
                        clr_result_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                        out_status_reg <= status_reg;
                        out_count_reg  <= cell_count_reg;
                        out_ratio_reg  <= ratio_reg;
                        out_diag_reg   <= diag_reg;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign cell_count  = out_count_reg;
    assign ratio_value = out_ratio_reg;
    assign is_diagonal = out_diag_reg;

endmodule
